// ===== rtl/kepler_equation_solver_unit_assert.svh =====
// Assertion macros for the Kepler solver checker.
`ifndef KEPLER_EQUATION_SOLVER_UNIT_ASSERT_SVH
`define KEPLER_EQUATION_SOLVER_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define KES_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kes check failed");

// Consequent holds in the cycle after the antecedent.
`define KES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kes check failed");

`endif

// ===== rtl/kes_pkg.sv =====
// Shared constants, types and the CORDIC angle table for the Kepler solver.
package kes_pkg;

  localparam int ANGLE_BITS   = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int CNT_W        = 5;
  localparam int XY_W         = 60;
  localparam int Z_W          = 34;

  localparam logic [23:0]            ECC_MAX    = 24'd16609443;
  localparam logic signed [XY_W-1:0] CORDIC_K   = 60'sd652032874;
  localparam logic [63:0]            INV_TWO_PI = 64'h28BE60DB9391054A;

  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_MAX_ITER  = 1'b1;

  typedef logic [CORDIC_STEPS-1:0][ANGLE_BITS-1:0] atan_tab_t;

  function automatic atan_tab_t build_atan_tab();
    atan_tab_t    tab;
    logic [63:0]  sum;
    logic [63:0]  term;
    logic [127:0] prod;
    logic [63:0]  hi;
    int           ex;
    tab = '0;
    tab[0] = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 3));
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      sum = '0;
      for (int k = 0; k < 32; k++) begin
        ex = 62 - i * (2 * k + 1);
        if (ex >= 0) begin
          term = (64'd1 << ex) / 64'(2 * k + 1);
          if (k % 2 == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
      prod = 128'(sum) * 128'(INV_TWO_PI);
      hi   = prod[127:64];
      tab[i] = ANGLE_BITS'((hi + (64'd1 << (61 - ANGLE_BITS))) >> (62 - ANGLE_BITS));
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan_tab();

  typedef struct packed {
    logic go;
    logic vec;
  } cordic_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ESQ,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_LOOP,
    ST_ROT_INIT,
    ST_ROT,
    ST_MUL_ES,
    ST_ES_ABS,
    ST_PP,
    ST_EC,
    ST_DIV_INIT,
    ST_DIV,
    ST_UPDATE,
    ST_FCHK,
    ST_MUL_RS,
    ST_VEC_INIT,
    ST_VEC
  } state_e;

endpackage

// ===== rtl/kes_cordic.sv =====
// Iterative CORDIC unit, rotation and vectoring, one micro-rotation per cycle.
module kes_cordic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  kes_pkg::cordic_req_t             req_i,
  input  logic signed [kes_pkg::XY_W-1:0]  x_i,
  input  logic signed [kes_pkg::XY_W-1:0]  y_i,
  input  logic signed [kes_pkg::Z_W-1:0]   z_i,
  output logic signed [kes_pkg::XY_W-1:0]  x_o,
  output logic signed [kes_pkg::XY_W-1:0]  y_o,
  output logic signed [kes_pkg::Z_W-1:0]   z_o,
  output logic                             done_o
);
  import kes_pkg::*;

  logic signed [XY_W-1:0] x_q, y_q, x_d, y_d, xs, ys;
  logic signed [Z_W-1:0]  z_q, z_d, ang;
  logic [CNT_W-1:0]       cnt_q;
  logic                   run_q, vec_q, done_q, pos;

  always_comb begin
    xs  = x_q >>> cnt_q;
    ys  = y_q >>> cnt_q;
    ang = $signed({2'b00, ATAN_TAB[cnt_q]});
    pos = vec_q ? !((!y_q[XY_W-1]) && (y_q != '0)) : !z_q[Z_W-1];
    x_d = pos ? x_q - ys : x_q + ys;
    y_d = pos ? y_q + xs : y_q - xs;
    z_d = pos ? z_q - ang : z_q + ang;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      vec_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        vec_q <= req_i.vec;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      x_q <= x_i;
      y_q <= y_i;
      z_q <= z_i;
    end else if (run_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign done_o = done_q;

endmodule

// ===== rtl/kepler_equation_solver_unit.sv =====
// Kepler equation solver: Newton iteration with shared CORDIC, multiplier and divider.
//
//  channel  | signals                                        | handshake
//  ---------+------------------------------------------------+-------------------------
//  request  | mean_anomaly_i, eccentricity_i                  | start high, busy low
//  result   | true_anomaly_o, iterations_used_o, converged_o | done_o, one cycle
//  config   | cfg_idx_i, cfg_data_i                           | cfg_we_i, no wait
//
//  A request keeps busy high until done_o is given; a result that lands on half a turn
//  skips the final rotation and vectoring. Each Newton iteration uses the 30-step
//  CORDIC and the 46-step restoring divider. Reset is asynchronous and active low; the
//  registers return to one arc second and 16 iterations. done_o rises as busy falls and
//  is a single-cycle strobe that cannot be held off.
module kepler_equation_solver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] mean_anomaly_i,
  input  logic [23:0] eccentricity_i,
  output logic        done_o,
  output logic [31:0] true_anomaly_o,
  output logic [5:0]  iterations_used_o,
  output logic        converged_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import kes_pkg::*;

  state_e state_q, state_d;

  logic [15:0] tol_q;
  logic [5:0]  maxit_q;

  logic [31:0]        m_q;
  logic [23:0]        e_q;
  logic signed [35:0] ea_q;
  logic [5:0]         iter_q;
  logic               conv_q, final_q, neg_q, esneg_q;
  logic signed [33:0] s_q, c_q;
  logic signed [67:0] prod_q, prod_d;
  logic [61:0]        u_q;
  logic [127:0]       acc_q;
  logic [2:0]         pcnt_q;
  logic signed [36:0] f_q;
  logic [31:0]        d30_q, rem_q;
  logic [45:0]        dq_q;
  logic [5:0]         dcnt_q;
  logic [48:0]        sv_q, res_q, bit_q;
  logic [4:0]         rcnt_q;
  logic               done_q, cv_q;
  logic [31:0]        ta_q;
  logic [5:0]         iu_q;

  cordic_req_t            creq;
  logic signed [XY_W-1:0] cx, cy, cx_o, cy_o;
  logic signed [Z_W-1:0]  cz, cz_o;
  logic                   cdone;

  logic signed [33:0] mul_a, mul_b;
  logic               mul_en, emit, near_half;

  logic [31:0]        z32;
  logic signed [33:0] zs, zf;
  logic               fneg;
  logic signed [XY_W-1:0] vx0;
  logic signed [36:0] dhalf;
  logic [35:0]        dhalf_mag, fm;
  logic [33:0]        tval;
  logic signed [36:0] est;
  logic signed [67:0] d54;
  logic [32:0]        rem_sh;
  logic               ge;
  logic signed [47:0] stp, en;
  logic [49:0]        rsum;
  logic [54:0]        es_mag;
  logic [127:0]       pp_add;

  kes_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (creq),
    .x_i    (cx),
    .y_i    (cy),
    .z_i    (cz),
    .x_o    (cx_o),
    .y_o    (cy_o),
    .z_o    (cz_o),
    .done_o (cdone)
  );

  // datapath helpers
  always_comb begin
    z32 = ea_q[31:0];
    zs  = (z32 > 32'h8000_0000) ? $signed({2'b00, z32}) - 34'sh1_0000_0000
                                : $signed({2'b00, z32});
    zf  = zs;
    fneg = 1'b0;
    if (zs > 34'sh4000_0000) begin
      zf   = zs - 34'sh8000_0000;
      fneg = 1'b1;
    end else if (zs < -34'sh4000_0000) begin
      zf   = zs + 34'sh8000_0000;
      fneg = 1'b1;
    end
    vx0       = (XY_W'(c_q) <<< 24) - $signed({6'b0, e_q, 30'b0});
    dhalf     = 37'(ea_q) - 37'sh8000_0000;
    dhalf_mag = dhalf[36] ? 36'(-dhalf) : 36'(dhalf);
    near_half = dhalf_mag < {20'b0, tol_q};
    tval      = 34'((acc_q[127:64] + 64'h2000_0000) >> 30);
    est       = esneg_q ? -$signed({3'b0, tval}) : $signed({3'b0, tval});
    fm        = f_q[36] ? 36'(-f_q) : 36'(f_q);
    d54       = 68'sh40_0000_0000_0000 - prod_q;
    rem_sh    = {rem_q, dq_q[45]};
    ge        = rem_sh >= {1'b0, d30_q};
    stp       = f_q[36] ? -$signed({2'b0, dq_q}) : $signed({2'b0, dq_q});
    en        = 48'(ea_q) - stp;
    rsum      = {1'b0, res_q} + {1'b0, bit_q};
    es_mag    = prod_q[67] ? 55'(-prod_q) : 55'(prod_q);
    case (pcnt_q)
      3'd1:    pp_add = {64'b0, prod_q[63:0]};
      3'd2:    pp_add = {32'b0, prod_q[63:0], 32'b0};
      3'd3:    pp_add = {32'b0, prod_q[63:0], 32'b0};
      3'd4:    pp_add = {prod_q[63:0], 64'b0};
      default: pp_add = '0;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (start) state_d = ST_ESQ;
      ST_ESQ:       state_d = ST_ROOT_INIT;
      ST_ROOT_INIT: state_d = ST_ROOT;
      ST_ROOT:      if (rcnt_q == 5'd24) state_d = ST_LOOP;
      ST_LOOP:      state_d = (iter_q < maxit_q) ? ST_ROT_INIT : ST_FCHK;
      ST_ROT_INIT:  state_d = ST_ROT;
      ST_ROT:       if (cdone) state_d = final_q ? ST_MUL_RS : ST_MUL_ES;
      ST_MUL_ES:    state_d = ST_ES_ABS;
      ST_ES_ABS:    state_d = ST_PP;
      ST_PP:        if (pcnt_q == 3'd4) state_d = ST_EC;
      ST_EC:        state_d = ST_DIV_INIT;
      ST_DIV_INIT:  state_d = ST_DIV;
      ST_DIV:       if (dcnt_q == 6'd45) state_d = ST_UPDATE;
      ST_UPDATE:    state_d = (dq_q < {30'b0, tol_q}) ? ST_FCHK : ST_LOOP;
      ST_FCHK:      state_d = near_half ? ST_IDLE : ST_ROT_INIT;
      ST_MUL_RS:    state_d = ST_VEC_INIT;
      ST_VEC_INIT:  state_d = ST_VEC;
      ST_VEC:       if (cdone) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    creq   = '0;
    cx     = CORDIC_K;
    cy     = '0;
    cz     = zf;
    mul_en = 1'b0;
    mul_a  = $signed({10'b0, e_q});
    mul_b  = s_q;
    emit   = 1'b0;
    case (state_q)
      ST_ESQ: begin
        mul_en = 1'b1;
        mul_b  = $signed({10'b0, e_q});
      end
      ST_ROT_INIT: begin
        creq.go = 1'b1;
      end
      ST_MUL_ES: begin
        mul_en = 1'b1;
      end
      ST_PP: begin
        mul_en = pcnt_q != 3'd4;
        mul_a  = pcnt_q[1] ? $signed({4'b0, u_q[61:32]}) : $signed({2'b0, u_q[31:0]});
        mul_b  = pcnt_q[0] ? $signed({2'b0, INV_TWO_PI[63:32]})
                           : $signed({2'b0, INV_TWO_PI[31:0]});
      end
      ST_EC: begin
        mul_en = 1'b1;
        mul_b  = c_q;
      end
      ST_FCHK: begin
        emit = near_half;
      end
      ST_MUL_RS: begin
        mul_en = 1'b1;
        mul_a  = $signed({9'b0, res_q[24:0]});
      end
      ST_VEC_INIT: begin
        creq.go  = 1'b1;
        creq.vec = 1'b1;
        if (vx0[XY_W-1]) begin
          cx = -vx0;
          cy = -XY_W'(prod_q);
          cz = 34'sh8000_0000;
        end else begin
          cx = vx0;
          cy = XY_W'(prod_q);
          cz = '0;
        end
      end
      ST_VEC: begin
        emit = cdone;
      end
      default: begin
        creq = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tol_q   <= 16'd3314;
      maxit_q <= 6'd16;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= emit;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TOLERANCE: tol_q   <= cfg_data_i;
          REG_MAX_ITER:  maxit_q <= cfg_data_i[5:0];
          default:       tol_q   <= tol_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= prod_d;
    if (emit) begin
      ta_q <= (state_q == ST_VEC) ? cz_o[31:0] : 32'h8000_0000;
      iu_q <= iter_q;
      cv_q <= conv_q;
    end
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          m_q     <= mean_anomaly_i;
          e_q     <= (eccentricity_i > ECC_MAX) ? ECC_MAX : eccentricity_i;
          ea_q    <= $signed({4'b0, mean_anomaly_i});
          iter_q  <= '0;
          conv_q  <= 1'b0;
          final_q <= 1'b0;
        end
      end
      ST_ROOT_INIT: begin
        sv_q   <= 49'h1_0000_0000_0000 - prod_q[48:0];
        res_q  <= '0;
        bit_q  <= 49'h1_0000_0000_0000;
        rcnt_q <= '0;
      end
      ST_ROOT: begin
        if ({1'b0, sv_q} >= rsum) begin
          sv_q  <= sv_q - rsum[48:0];
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q  <= bit_q >> 2;
        rcnt_q <= rcnt_q + 1'b1;
      end
      ST_ROT_INIT: begin
        neg_q <= fneg;
      end
      ST_ROT: begin
        if (cdone) begin
          s_q <= neg_q ? -34'(cy_o) : 34'(cy_o);
          c_q <= neg_q ? -34'(cx_o) : 34'(cx_o);
        end
      end
      ST_ES_ABS: begin
        u_q     <= {es_mag[53:0], 8'b0};
        esneg_q <= prod_q[67];
        acc_q   <= '0;
        pcnt_q  <= '0;
      end
      ST_PP: begin
        acc_q  <= acc_q + pp_add;
        pcnt_q <= pcnt_q + 1'b1;
      end
      ST_EC: begin
        f_q <= 37'(ea_q) - $signed({5'b0, m_q}) - est;
      end
      ST_DIV_INIT: begin
        d30_q  <= (d54 < 68'sh1000_0000_0000) ? 32'h0010_0000 : d54[55:24];
        rem_q  <= {12'b0, fm[35:16]};
        dq_q   <= {fm[15:0], 30'b0};
        dcnt_q <= '0;
      end
      ST_DIV: begin
        rem_q  <= ge ? 32'(rem_sh - {1'b0, d30_q}) : rem_sh[31:0];
        dq_q   <= {dq_q[44:0], ge};
        dcnt_q <= dcnt_q + 1'b1;
      end
      ST_UPDATE: begin
        if (en < -48'sh1_0000_0000) begin
          ea_q <= -36'sh1_0000_0000;
        end else if (en > 48'sh2_0000_0000) begin
          ea_q <= 36'sh2_0000_0000;
        end else begin
          ea_q <= 36'(en);
        end
        iter_q <= iter_q + 1'b1;
        if (dq_q < {30'b0, tol_q}) conv_q <= 1'b1;
      end
      ST_FCHK: begin
        final_q <= 1'b1;
      end
      default: begin
        final_q <= final_q;
      end
    endcase
  end

  assign busy              = state_q != ST_IDLE;
  assign done_o            = done_q;
  assign true_anomaly_o    = ta_q;
  assign iterations_used_o = iu_q;
  assign converged_o       = cv_q;

endmodule

// ===== rtl/kes_check.sv =====
// Port-level checker for the Kepler solver and its bind to the top level.
`include "kepler_equation_solver_unit_assert.svh"

module kes_check (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [5:0] iterations_used_o,
  input logic       converged_o
);

  `KES_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `KES_ASSERT_NOW(a_done_idle, done_o, !busy)
  `KES_ASSERT_NOW(a_fall_done, $fell(busy), done_o)
  `KES_ASSERT_NOW(a_conv_iter, done_o && converged_o, iterations_used_o != 6'd0)

endmodule

bind kepler_equation_solver_unit kes_check u_kes_check (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the Kepler equation solver unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kes_pkg::*;

  localparam longint FULL = 64'sd1 <<< 32;
  localparam longint HALF = 64'sd1 <<< 31;
  localparam longint QUAR = 64'sd1 <<< 30;
  localparam int     LIMIT = 25_000_000;

  typedef enum logic [1:0] {K_REQ, K_CFG, K_HOLD} entry_kind_e;

  typedef struct {
    entry_kind_e kind;
    logic [31:0] a;
    logic [23:0] b;
  } entry_t;

  typedef struct {
    logic [31:0] anomaly;
    logic [5:0]  iters;
    logic        conv;
  } solution_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] mean_anomaly_i = '0;
  logic [23:0] eccentricity_i = '0;
  logic        done_o;
  logic [31:0] true_anomaly_o;
  logic [5:0]  iterations_used_o;
  logic        converged_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  kepler_equation_solver_unit dut (.*);

  always #4 clk_i = ~clk_i;

  entry_t    pending_q[$];
  solution_t solution_q[$];
  longint    angle_step[CORDIC_STEPS];
  longint unsigned tol_reg = 3314;
  int        maxit_reg = 16;
  int        errors = 0;
  int        acc_cnt = 0;
  int        issued = 0;
  int        hold_cnt = 0;
  int        cycles = 0;

  function automatic longint unsigned mul_high(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[127:64];
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic void build_steps();
    longint sum;
    longint unsigned term;
    int ex;
    angle_step[0] = FULL / 8;
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      sum = 0;
      for (int k = 0; k < 64; k++) begin
        ex = 62 - i * (2 * k + 1);
        if (ex >= 0) begin
          term = (64'd1 << ex) / longint'(2 * k + 1);
          sum = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
        end
      end
      angle_step[i] = longint'((mul_high(sum, INV_TWO_PI) + (64'd1 << 29)) >> 30);
    end
  endfunction

  task automatic rotate(input longint ang, output longint sn, output longint cs);
    longint z, x, y, xn;
    bit neg;
    z = ang & (FULL - 1);
    x = 652032874;
    y = 0;
    neg = 0;
    if (z > HALF) z = z - FULL;
    if (z > QUAR) begin
      z = z - HALF;
      neg = 1;
    end else if (z < -QUAR) begin
      z = z + HALF;
      neg = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        y = y + (x >>> i);
        z = z - angle_step[i];
      end else begin
        xn = x + (y >>> i);
        y = y - (x >>> i);
        z = z + angle_step[i];
      end
      x = xn;
    end
    sn = neg ? -y : y;
    cs = neg ? -x : x;
  endtask

  function automatic longint vector_angle(longint y, longint x);
    longint z, xn;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y > 0) begin
        xn = x + (y >>> i);
        y = y - (x >>> i);
        z = z + angle_step[i];
      end else begin
        xn = x - (y >>> i);
        y = y + (x >>> i);
        z = z - angle_step[i];
      end
      x = xn;
    end
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  task automatic solve_kepler(input logic [31:0] m32, input logic [23:0] ecc,
                              output solution_t sol);
    longint e, m, ea, s, c, es, est, f, d54, stp, v, root, y, x;
    longint unsigned t, d30, fm, q;
    int it;
    bit conv;
    e = (ecc > ECC_MAX) ? longint'(ECC_MAX) : longint'(ecc);
    m = longint'({32'd0, m32});
    ea = m;
    it = 0;
    conv = 0;
    while (it < maxit_reg && !conv) begin
      rotate(ea, s, c);
      es = e * s;
      t = (mul_high(mag(es) << 8, INV_TWO_PI) + (64'd1 << 29)) >> 30;
      est = es < 0 ? -longint'(t) : longint'(t);
      f = ea - m - est;
      d54 = (64'sd1 <<< 54) - e * c;
      d30 = (d54 < (64'sd1 <<< 44)) ? (64'd1 << 20) : (longint'(d54) >>> 24);
      fm = mag(f);
      q = ((fm / d30) << 30) + (((fm % d30) << 30) / d30);
      stp = f < 0 ? -longint'(q) : longint'(q);
      ea = ea - stp;
      if (ea < -FULL) ea = -FULL;
      if (ea > 2 * FULL) ea = 2 * FULL;
      it++;
      if (q < tol_reg) conv = 1;
    end
    if (mag(ea - HALF) < tol_reg) begin
      v = HALF;
    end else begin
      rotate(ea, s, c);
      root = longint'(int_sqrt((64'd1 << 48) - longint'(e * e)));
      y = root * s;
      x = c * (64'sd1 <<< 24) - e * (64'sd1 <<< 30);
      v = vector_angle(y, x);
    end
    sol.anomaly = v[31:0];
    sol.iters = it[5:0];
    sol.conv = conv;
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk_i) begin
    solution_t sol, want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (done_o) begin
      if (solution_q.size() == 0) begin
        report("unexpected result", 64'(true_anomaly_o), 64'd0);
      end else begin
        want = solution_q.pop_front();
        if (true_anomaly_o !== want.anomaly)
          report("true_anomaly", 64'(true_anomaly_o), 64'(want.anomaly));
        if (iterations_used_o !== want.iters)
          report("iterations", 64'(iterations_used_o), 64'(want.iters));
        if (converged_o !== want.conv)
          report("converged", 64'(converged_o), 64'(want.conv));
      end
    end
    if (rst_ni && start && !busy) begin
      solve_kepler(mean_anomaly_i, eccentricity_i, sol);
      solution_q.push_back(sol);
      acc_cnt++;
    end
  end

  always @(negedge clk_i) begin
    logic   nxt_start, nxt_we;
    entry_t head;
    bit     quiet;
    nxt_start = start;
    nxt_we = 1'b0;
    if (rst_ni) begin
      if (start && acc_cnt != issued) begin
        issued++;
        nxt_start = 1'b0;
      end
      quiet = solution_q.size() == 0 && !busy && !start;
      if (!nxt_start && pending_q.size() > 0) begin
        head = pending_q[0];
        case (head.kind)
          K_REQ: begin
            if ((issued > 500 && issued < 700) || $urandom_range(99) >= 29) begin
              mean_anomaly_i <= head.a;
              eccentricity_i <= head.b;
              nxt_start = 1'b1;
              void'(pending_q.pop_front());
            end
          end
          K_CFG: begin
            if (quiet) begin
              if (hold_cnt < 40) begin
                hold_cnt++;
              end else begin
                hold_cnt = 0;
                nxt_we = 1'b1;
                cfg_idx_i <= head.a[0];
                cfg_data_i <= head.b[15:0];
                if (head.a[0] == REG_TOLERANCE) tol_reg = head.b[15:0];
                else maxit_reg = head.b[5:0];
                void'(pending_q.pop_front());
              end
            end
          end
          default: begin
            if (quiet) void'(pending_q.pop_front());
          end
        endcase
      end
    end
    start <= nxt_start;
    cfg_we_i <= nxt_we;
  end

  function automatic void add_req(logic [31:0] m, logic [23:0] e);
    entry_t x;
    x.kind = K_REQ;
    x.a = m;
    x.b = e;
    pending_q.push_back(x);
  endfunction

  function automatic void add_cfg(logic idx, logic [15:0] val);
    entry_t x;
    x.kind = K_CFG;
    x.a = {31'd0, idx};
    x.b = {8'd0, val};
    pending_q.push_back(x);
  endfunction

  function automatic void add_random(int n);
    logic [31:0] m;
    logic [23:0] e;
    entry_t x;
    for (int i = 0; i < n; i++) begin
      m = $urandom;
      case ($urandom_range(5))
        0: e = 24'($urandom_range(16777215, 16500000));
        1: e = 24'($urandom_range(1000));
        2: begin
          m = 32'h8000_0000 + $urandom_range(4000) - 2000;
          e = 24'($urandom_range(16777215));
        end
        default: e = 24'($urandom_range(16777215));
      endcase
      add_req(m, e);
      if ($urandom_range(150) == 0) begin
        x.kind = K_HOLD;
        pending_q.push_back(x);
      end
    end
  endfunction

  initial begin
    entry_t hx;
    build_steps();
    add_req(32'h0000_0000, 24'h000000);
    add_req(32'hFFFF_FFFF, 24'hFFFFFF);
    add_req(32'h8000_0000, 24'h800000);
    add_req(32'h8000_0000, 24'hFFFFFF);
    add_req(32'h4000_0000, 24'd16609443);
    add_req(32'hC000_0000, 24'd16609444);
    add_req(32'h0000_0001, 24'hFFFFFF);
    add_req(32'hFFFF_FFFF, 24'h000000);
    add_req(32'h7FFF_FF00, 24'h400000);
    add_req(32'h8000_0100, 24'h000001);
    add_req(32'h5555_5555, 24'hAAAAAA);
    add_req(32'hAAAA_AAAA, 24'h555555);
    add_req(32'h2000_0000, 24'hF00000);
    add_req(32'h0000_1000, 24'hFD0000);
    hx.kind = K_HOLD;
    pending_q.push_back(hx);
    add_cfg(REG_TOLERANCE, 16'd0);
    add_cfg(REG_MAX_ITER, 16'hFFC5);
    add_random(8);
    add_cfg(REG_MAX_ITER, 16'h0040);
    add_random(8);
    add_cfg(REG_TOLERANCE, 16'hFFFF);
    add_cfg(REG_MAX_ITER, 16'd63);
    add_random(100);
    add_cfg(REG_TOLERANCE, 16'd1);
    add_random(10);
    for (int p = 0; p < 10; p++) begin
      add_cfg(REG_TOLERANCE, 16'($urandom_range(65535, 1)));
      add_cfg(REG_MAX_ITER, {6'($urandom_range(1023)), 10'($urandom_range(20, 1))});
      add_random(110);
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_q.size() == 0 && solution_q.size() == 0 && !start && !busy);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && solution_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
